[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent holds -> consequent holds in the same cycle
`define KBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbt assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define KBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbt assertion failed");
`endif

[design/kbt_pkg.sv]
`default_nettype none
package kbt_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_KEYS_DEF    = 128;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CMD_FIFO_DEPTH  = 2;

    localparam int CODE_W     = 7;
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 3;
    localparam int MOD_W      = 3;
    localparam int OUT_CNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [KIND_W-1:0] KIND_EVENT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HELD  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_L = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_R = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_L   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_R   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_L  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_R  = 3'd6;

    localparam int MOD_SHIFT = 0;
    localparam int MOD_ALT   = 1;
    localparam int MOD_CTRL  = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EVENT,
        OP_POP,
        OP_DOWN_CNT,
        OP_UP_CNT,
        OP_HELD,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
        logic              up;
        logic [TIME_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic              repeat_enable;
        logic [CODE_W-1:0] shift_l;
        logic [CODE_W-1:0] shift_r;
        logic [CODE_W-1:0] alt_l;
        logic [CODE_W-1:0] alt_r;
        logic [CODE_W-1:0] ctrl_l;
        logic [CODE_W-1:0] ctrl_r;
    } cfg_t;

    typedef struct packed {
        logic                 key_valid;
        logic [CODE_W-1:0]    key_code;
        logic [MOD_W-1:0]     key_modifiers;
        logic [TIME_W-1:0]    key_time;
        logic [OUT_CNT_W-1:0] count_value;
        logic [TIME_W-1:0]    time_value;
        logic                 queue_nonempty;
        logic [MOD_W-1:0]     current_modifiers;
        logic [CODE_W-1:0]    last_pressed_key;
        logic [CODE_W-1:0]    last_released_key;
    } res_t;
endpackage
`default_nettype wire

[design/kbt_if.sv]
`default_nettype none
interface kbt_evt_if import kbt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [CODE_W-1:0]        scancode;
    logic                     released;
    logic signed [TIME_W-1:0] now;

    modport source (output valid, kind, scancode, released, now, input ready);
    modport sink (input valid, kind, scancode, released, now, output ready);
endinterface

interface kbt_res_if import kbt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     key_valid;
    logic [CODE_W-1:0]        key_code;
    logic [MOD_W-1:0]         key_modifiers;
    logic signed [TIME_W-1:0] key_time;
    logic [OUT_CNT_W-1:0]     count_value;
    logic signed [TIME_W-1:0] time_value;
    logic                     queue_nonempty;
    logic [MOD_W-1:0]         current_modifiers;
    logic [CODE_W-1:0]        last_pressed_key;
    logic [CODE_W-1:0]        last_released_key;

    modport source (output valid, key_valid, key_code, key_modifiers, key_time,
        count_value, time_value, queue_nonempty, current_modifiers,
        last_pressed_key, last_released_key, input ready);
    modport sink (input valid, key_valid, key_code, key_modifiers, key_time,
        count_value, time_value, queue_nonempty, current_modifiers,
        last_pressed_key, last_released_key, output ready);
endinterface
`default_nettype wire

[design/kbt_ram.sv]
`default_nettype none
module kbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/kbt_front.sv]
`default_nettype none
module kbt_front import kbt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kbt_evt_if.sink    evt,
    output logic       cmd_valid,
    input  wire logic  cmd_ready,
    output cmd_t       cmd
);
    logic cmd_valid_reg, cmd_valid_next;
    cmd_t cmd_reg, cmd_next;
    logic inr;

    assign evt.ready = !cmd_valid_reg || cmd_ready;
    assign inr = int'(evt.scancode) < NUM_KEYS;

    always_comb
    begin
        cmd_next      = cmd_reg;
        cmd_next.code = evt.scancode;
        cmd_next.up   = evt.released;
        cmd_next.now  = evt.now;
        case (evt.kind)
            KIND_EVENT: cmd_next.op = inr ? OP_EVENT : OP_NONE;
            KIND_POP:   cmd_next.op = OP_POP;
            KIND_DOWN:  cmd_next.op = inr ? OP_DOWN_CNT : OP_NONE;
            KIND_UP:    cmd_next.op = inr ? OP_UP_CNT : OP_NONE;
            KIND_HELD:  cmd_next.op = inr ? OP_HELD : OP_NONE;
            KIND_FLUSH: cmd_next.op = OP_FLUSH;
            default:    cmd_next.op = OP_NONE;
        endcase
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        if (evt.valid && evt.ready)
        begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
endmodule
`default_nettype wire

[design/kbt_cmd_fifo.sv]
`default_nettype none
module kbt_cmd_fifo import kbt_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire cmd_t  push_data,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output cmd_t       pop_data
);
    localparam int PW = $clog2(CMD_FIFO_DEPTH);

    cmd_t slot_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign push_ready = cnt_reg != (PW+1)'(CMD_FIFO_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[design/kbt_back.sv]
`default_nettype none
module kbt_back import kbt_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd,
    kbt_res_if.source  res
);
    localparam int KW  = $clog2(NUM_KEYS);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = COUNT_WIDTH;
    localparam int EW  = 2 * TIME_W + 2 * CW;
    localparam int QEW = CODE_W + MOD_W + TIME_W;

    typedef enum logic [1:0] {
        S_FETCH = 2'b01,
        S_EXEC  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [NUM_KEYS-1:0] kd_reg, kd_next, vld_reg, vld_next;
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next, tail_inc, head_inc;
    logic [TIME_W-1:0] flush_time_reg, flush_time_next;
    logic [CODE_W-1:0] last_press_reg, last_press_next, last_rel_reg, last_rel_next;
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    logic [KW-1:0] idx;
    logic [EW-1:0] tbl_rd, tbl_wd;
    logic tbl_we;
    logic [QEW-1:0] q_rd, q_wd;
    logic q_we;
    logic start;

    logic [TIME_W-1:0] ps, ht, ps_n, ht_n;
    logic [CW-1:0] pc, rc, pc_n, rc_n;
    logic enq;

    function automatic logic held(input logic [NUM_KEYS-1:0] kd, input logic [CODE_W-1:0] c);
        logic r;
        r = (int'(c) < NUM_KEYS) && kd[KW'(c)];
        return r;
    endfunction

    function automatic logic [MOD_W-1:0] mods(input logic [NUM_KEYS-1:0] kd, input cfg_t c);
        logic [MOD_W-1:0] m;
        m            = '0;
        m[MOD_SHIFT] = held(kd, c.shift_l) || held(kd, c.shift_r);
        m[MOD_ALT]   = held(kd, c.alt_l) || held(kd, c.alt_r);
        m[MOD_CTRL]  = held(kd, c.ctrl_l) || held(kd, c.ctrl_r);
        return m;
    endfunction

    assign idx       = KW'(cmd.code);
    assign start     = (state_reg == S_FETCH) && cmd_valid && (!res_valid_reg || res.ready);
    assign cmd_ready = state_reg == S_EXEC;
    assign tail_inc  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    kbt_ram #(.WIDTH(EW), .DEPTH(NUM_KEYS)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (idx),
        .wdata (tbl_wd),
        .raddr (idx),
        .rdata (tbl_rd)
    );

    kbt_ram #(.WIDTH(QEW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wd),
        .raddr (head_reg),
        .rdata (q_rd)
    );

    // entry not written since flush reads as the flush state
    always_comb
    begin
        if (vld_reg[idx])
        begin
            {ps, ht, pc, rc} = tbl_rd;
        end
        else
        begin
            ps = flush_time_reg;
            ht = '0;
            pc = '0;
            rc = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kd_next         = kd_reg;
        vld_next        = vld_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        flush_time_next = flush_time_reg;
        last_press_next = last_press_reg;
        last_rel_next   = last_rel_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_next        = res_reg;
        ps_n            = ps;
        ht_n            = ht;
        pc_n            = pc;
        rc_n            = rc;
        tbl_we          = 1'b0;
        enq             = 1'b0;
        q_we            = 1'b0;
        q_wd            = '0;

        case (state_reg)
            S_FETCH:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FETCH;
                res_next   = '0;
                case (cmd.op)
                    OP_EVENT:
                    begin
                        if (cmd.up)
                        begin
                            last_rel_next = cmd.code;
                            kd_next[idx]  = 1'b0;
                            rc_n          = (&rc) ? rc : rc + 1'b1;
                            ht_n          = ht + (cmd.now - ps);
                            tbl_we        = 1'b1;
                        end
                        else
                        begin
                            last_press_next = cmd.code;
                            if (!kd_reg[idx])
                            begin
                                ps_n         = cmd.now;
                                kd_next[idx] = 1'b1;
                                pc_n         = (&pc) ? pc : pc + 1'b1;
                                tbl_we       = 1'b1;
                                enq          = 1'b1;
                            end
                            else
                            begin
                                enq = cfg.repeat_enable;
                            end
                        end
                        if (enq && (tail_inc != head_reg))
                        begin
                            q_we      = 1'b1;
                            q_wd      = {mods(kd_next, cfg), cmd.code, cmd.now};
                            tail_next = tail_inc;
                        end
                    end
                    OP_POP:
                    begin
                        if (head_reg != tail_reg)
                        begin
                            res_next.key_valid = 1'b1;
                            {res_next.key_modifiers, res_next.key_code, res_next.key_time} = q_rd;
                            head_next = head_inc;
                        end
                    end
                    OP_DOWN_CNT:
                    begin
                        res_next.count_value = OUT_CNT_W'(pc);
                        pc_n                 = '0;
                        tbl_we               = 1'b1;
                    end
                    OP_UP_CNT:
                    begin
                        res_next.count_value = OUT_CNT_W'(rc);
                        rc_n                 = '0;
                        tbl_we               = 1'b1;
                    end
                    OP_HELD:
                    begin
                        if (!kd_reg[idx])
                        begin
                            res_next.time_value = ht;
                            ht_n                = '0;
                        end
                        else
                        begin
                            res_next.time_value = cmd.now - ps;
                            ps_n                = cmd.now;
                        end
                        tbl_we = 1'b1;
                    end
                    OP_FLUSH:
                    begin
                        kd_next         = '0;
                        vld_next        = '0;
                        head_next       = '0;
                        tail_next       = '0;
                        flush_time_next = cmd.now;
                    end
                    default:
                    begin
                    end
                endcase
                if (tbl_we)
                begin
                    vld_next[idx] = 1'b1;
                end
                res_next.queue_nonempty    = head_next != tail_next;
                res_next.current_modifiers = mods(kd_next, cfg);
                res_next.last_pressed_key  = last_press_next;
                res_next.last_released_key = last_rel_next;
                res_valid_next             = 1'b1;
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase
    end

    assign tbl_wd = {ps_n, ht_n, pc_n, rc_n};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FETCH;
            kd_reg         <= '0;
            vld_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            flush_time_reg <= '0;
            last_press_reg <= '0;
            last_rel_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kd_reg         <= kd_next;
            vld_reg        <= vld_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            flush_time_reg <= flush_time_next;
            last_press_reg <= last_press_next;
            last_rel_reg   <= last_rel_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res.valid             = res_valid_reg;
    assign res.key_valid         = res_reg.key_valid;
    assign res.key_code          = res_reg.key_code;
    assign res.key_modifiers     = res_reg.key_modifiers;
    assign res.key_time          = res_reg.key_time;
    assign res.count_value       = res_reg.count_value;
    assign res.time_value        = res_reg.time_value;
    assign res.queue_nonempty    = res_reg.queue_nonempty;
    assign res.current_modifiers = res_reg.current_modifiers;
    assign res.last_pressed_key  = res_reg.last_pressed_key;
    assign res.last_released_key = res_reg.last_released_key;
endmodule
`default_nettype wire

[design/keyboard_event_tracker.sv]
// Keyboard event tracker.
// evt: one word per key event or access (kind, scancode, released, now),
//   valid/ready handshake. res: exactly one result word per evt word, in order.
// cfg: write port (cfg_we, cfg_index, cfg_data) for repeat enable and the six
//   modifier scan codes; write only while the block is idle.
// The front registers and classifies each word into a two-word command queue;
// the back runs each command through a fetch state that reads the key table RAM
// and key queue RAM and an exec state that updates them and loads the result
// register; it takes no new command until the last one has left exec. An evt word
// passes the front register, command queue, fetch, exec and result register.
// Flush uses the same states: per-key valid bits clear in one step.
// Reset clears all key state, key queue and control registers (repeat enabled).
// A stalled res holds its word; the back waits, the command queue fills and
// then evt.ready drops.
`default_nettype none
`include "assert_macros.svh"
module keyboard_event_tracker import kbt_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    kbt_evt_if.sink                    evt,
    kbt_res_if.source                  res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    cfg_t cfg_reg, cfg_next;
    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPEAT:  cfg_next.repeat_enable = cfg_data[0];
                CFG_SHIFT_L: cfg_next.shift_l = cfg_data;
                CFG_SHIFT_R: cfg_next.shift_r = cfg_data;
                CFG_ALT_L:   cfg_next.alt_l = cfg_data;
                CFG_ALT_R:   cfg_next.alt_r = cfg_data;
                CFG_CTRL_L:  cfg_next.ctrl_l = cfg_data;
                CFG_CTRL_R:  cfg_next.ctrl_r = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg               <= '0;
            cfg_reg.repeat_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kbt_front #(.NUM_KEYS(NUM_KEYS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    kbt_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_cmd)
    );

    kbt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_KEYS    (NUM_KEYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .res       (res)
    );

    `KBT_ASSERT_NEXT(a_front_holds, f_valid && !f_ready, f_valid && $stable(f_cmd))
    `KBT_ASSERT_NOW(a_no_key_fields, res.valid && !res.key_valid, res.key_code == '0 && res.key_modifiers == '0 && res.key_time == '0)
    `KBT_ASSERT_NOW(a_one_value, res.valid && res.count_value != '0, res.time_value == '0 && !res.key_valid)
endmodule
`default_nettype wire
